[design/voxel_grid_ray_traversal_assert.svh]
// ----------------------------------------------------------------------------
// Voxel grid ray traversal assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_ASSERT_SVH

// same-cycle implication
`define VGRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgrt assertion failed");

// next-cycle implication
`define VGRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgrt assertion failed");

`endif

[design/vgrt_pkg.sv]
// ----------------------------------------------------------------------------
// vgrt_pkg
// Types and constants shared by the voxel ray traversal modules.
// ----------------------------------------------------------------------------
package vgrt_pkg;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 32;
    localparam int OUT_W    = 5;
    localparam int ORG_W    = 15;
    localparam int DIR_W    = 16;
    localparam int REACH_W  = 16;
    localparam int TIME_W   = 32;
    localparam int DIV_W    = 5;
    localparam logic [DIV_W-1:0] DIV_LAST = 5'd30;  // quotient has 31 bits
    localparam logic [1:0] LAST_AX = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_MUL,
        ST_CHK0,
        ST_TEST0,
        ST_DIST,
        ST_CMP,
        ST_STEP,
        ST_CHK,
        ST_TEST,
        ST_HIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic load;
        logic wr;
        logic clr_step;
        logic div_step;
        logic mul_step;
        logic dist_step;
        logic adv;
        logic res_hit;
        logic res_miss;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_cast;
        logic div_done;
        logic ax_last;
        logic in_grid;
        logic solid;
        logic far;
        logic cap;
        logic out_busy;
    } status_t;

endpackage

[design/vgrt_ctrl.sv]
// ----------------------------------------------------------------------------
// vgrt_ctrl
// Sequencer for clearing, voxel writes and the ray walk.
// ----------------------------------------------------------------------------
module vgrt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  vgrt_pkg::status_t st,
    output vgrt_pkg::cmd_t    cmd
);

    vgrt_pkg::state_t state_reg;
    vgrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vgrt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vgrt_pkg::ST_CLEAR:
            begin
                if (st.clr_done)
                    state_next = vgrt_pkg::ST_IDLE;
            end
            vgrt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = vgrt_pkg::ST_DECODE;
            end
            vgrt_pkg::ST_DECODE:
            begin
                state_next = st.is_cast ? vgrt_pkg::ST_DIV : vgrt_pkg::ST_IDLE;
            end
            vgrt_pkg::ST_DIV:
            begin
                if (st.div_done)
                    state_next = vgrt_pkg::ST_MUL;
            end
            vgrt_pkg::ST_MUL:
            begin
                if (st.ax_last)
                    state_next = vgrt_pkg::ST_CHK0;
            end
            vgrt_pkg::ST_CHK0:
            begin
                state_next = st.in_grid ? vgrt_pkg::ST_TEST0 : vgrt_pkg::ST_MISS;
            end
            vgrt_pkg::ST_TEST0:
            begin
                state_next = st.solid ? vgrt_pkg::ST_HIT : vgrt_pkg::ST_DIST;
            end
            vgrt_pkg::ST_DIST:
            begin
                if (st.ax_last)
                    state_next = vgrt_pkg::ST_CMP;
            end
            vgrt_pkg::ST_CMP:
            begin
                state_next = (st.cap || st.far) ? vgrt_pkg::ST_MISS : vgrt_pkg::ST_STEP;
            end
            vgrt_pkg::ST_STEP:
            begin
                state_next = vgrt_pkg::ST_CHK;
            end
            vgrt_pkg::ST_CHK:
            begin
                state_next = st.in_grid ? vgrt_pkg::ST_TEST : vgrt_pkg::ST_MISS;
            end
            vgrt_pkg::ST_TEST:
            begin
                state_next = st.solid ? vgrt_pkg::ST_HIT : vgrt_pkg::ST_DIST;
            end
            vgrt_pkg::ST_HIT, vgrt_pkg::ST_MISS:
            begin
                if (!st.out_busy)
                    state_next = vgrt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vgrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            vgrt_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
            vgrt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            vgrt_pkg::ST_DECODE: cmd.wr        = !st.is_cast;
            vgrt_pkg::ST_DIV:    cmd.div_step  = 1'b1;
            vgrt_pkg::ST_MUL:    cmd.mul_step  = 1'b1;
            vgrt_pkg::ST_DIST:   cmd.dist_step = 1'b1;
            vgrt_pkg::ST_STEP:   cmd.adv       = 1'b1;
            vgrt_pkg::ST_HIT:    cmd.res_hit   = !st.out_busy;
            vgrt_pkg::ST_MISS:   cmd.res_miss  = !st.out_busy;
            default:             cmd           = '0;
        endcase
    end

endmodule

[design/vgrt_dp.sv]
// ----------------------------------------------------------------------------
// vgrt_dp
// Occupancy memory, inverse-step divider, crossing times and DDA stepping.
// ----------------------------------------------------------------------------
module vgrt_dp
#(
    parameter int GRID_BITS = 5,
    parameter int FRAC_BITS = 10,
    parameter int MAX_STEPS = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [vgrt_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [vgrt_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    input  vgrt_pkg::cmd_t                  cmd,
    output vgrt_pkg::status_t               st
);

    localparam int AW    = 3 * GRID_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int GSZ   = 1 << GRID_BITS;
    localparam int HALF  = 1 << (FRAC_BITS - 1);
    localparam int RW    = 17 - FRAC_BITS;
    localparam int PW    = ((RW > GRID_BITS) ? RW : GRID_BITS) + 2;
    localparam int DW    = (((GRID_BITS + FRAC_BITS) > 15) ? (GRID_BITS + FRAC_BITS) : 15) + 2;
    localparam int DSW   = 2 * DW + 2;
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int TW    = vgrt_pkg::TIME_W;
    localparam int BW    = FRAC_BITS + 1;
    localparam int PRW   = TW + 1 + FRAC_BITS;

    // input item
    logic                            act_reg;
    logic [vgrt_pkg::OUT_W-1:0]      vx_reg, vy_reg, vz_reg;
    logic                            solid_reg;
    logic [vgrt_pkg::ORG_W-1:0]      org_reg [3];
    logic [vgrt_pkg::DIR_W-1:0]      mag_reg [3];
    logic                            neg_reg [3];
    logic                            zero_reg [3];
    logic [2*vgrt_pkg::REACH_W-1:0]  lim_reg;

    // walk state
    logic signed [PW-1:0]            pos_reg [3];
    logic signed [PW-1:0]            last_reg [3];
    logic [TW-1:0]                   inv_reg [3];
    logic [TW-1:0]                   tm_reg [3];
    logic [vgrt_pkg::DIR_W-1:0]      rem_reg [3];
    logic [TW-1:0]                   quo_reg [3];
    logic [vgrt_pkg::DIV_W-1:0]      div_cnt_reg;
    logic [1:0]                      ax_reg;
    logic [DSW-1:0]                  dist_reg;
    logic [SW-1:0]                   steps_reg;
    logic [AW-1:0]                   clr_cnt_reg;

    // result
    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [vgrt_pkg::OUT_W-1:0]      hx_reg, hy_reg, hz_reg, px_reg, py_reg, pz_reg;

    logic                            mem [0:DEPTH-1];
    logic                            rdata_reg;

    // input unpack
    logic [vgrt_pkg::ORG_W-1:0]      in_org [3];
    logic signed [vgrt_pkg::DIR_W-1:0] in_dir [3];
    logic [vgrt_pkg::REACH_W-1:0]    in_reach;
    logic [16:0]                     in_rnd [3];

    // combinational helpers
    logic                            in_grid;
    logic [AW-1:0]                   raddr;
    logic [AW-1:0]                   waddr;
    logic                            we;
    logic                            wdata;
    logic                            wr_ok;
    logic [16:0]                     base;
    logic [16:0]                     b_full;
    logic [BW-1:0]                   b;
    logic [TW-1:0]                   inv_src;
    logic [PRW-1:0]                  prod;
    logic [TW:0]                     t_full;
    logic signed [DW-1:0]            dd;
    logic signed [2*DW-1:0]          sq;
    logic [DSW-1:0]                  dist_base;
    logic [1:0]                      sel;
    logic [TW:0]                     tsum;
    logic [vgrt_pkg::DIR_W:0]        trial [3];
    logic                            div_bit;
    logic [1:0]                      ax_inc;

    always_comb
    begin
        in_org[0] = s_tdata[30:16];
        in_org[1] = s_tdata[45:31];
        in_org[2] = s_tdata[60:46];
        in_dir[0] = $signed(s_tdata[76:61]);
        in_dir[1] = $signed(s_tdata[92:77]);
        in_dir[2] = $signed(s_tdata[108:93]);
        in_reach  = s_tdata[124:109];
        for (int a = 0; a < 3; a++)
        begin
            in_rnd[a] = 17'(in_org[a]) + 17'(HALF);
        end
    end

    always_comb
    begin
        in_grid = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (pos_reg[a][PW-1:GRID_BITS] != '0)
                in_grid = 1'b0;
        end
        raddr = {pos_reg[0][GRID_BITS-1:0], pos_reg[1][GRID_BITS-1:0],
                 pos_reg[2][GRID_BITS-1:0]};
        wr_ok = ({4'b0, vx_reg} < 9'(GSZ)) && ({4'b0, vy_reg} < 9'(GSZ))
                && ({4'b0, vz_reg} < 9'(GSZ));
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = 1'b0;
        end
        else
        begin
            we    = cmd.wr && wr_ok;
            waddr = {GRID_BITS'(vx_reg), GRID_BITS'(vy_reg), GRID_BITS'(vz_reg)};
            wdata = solid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // first crossing time for axis ax_reg
    always_comb
    begin
        base    = 17'(pos_reg[ax_reg]) << FRAC_BITS;
        if (!neg_reg[ax_reg])
            b_full = base + 17'(HALF) - 17'(org_reg[ax_reg]);
        else
            b_full = 17'(org_reg[ax_reg]) + 17'(HALF) - base;
        b       = b_full[BW-1:0];
        inv_src = zero_reg[ax_reg] ? '1 : quo_reg[ax_reg];
        prod    = PRW'(inv_src) * PRW'(b);
        t_full  = prod[PRW-1:FRAC_BITS];
    end

    // squared distance term for axis ax_reg
    always_comb
    begin
        dd        = $signed(DW'(org_reg[ax_reg])) - (DW'(pos_reg[ax_reg]) <<< FRAC_BITS);
        sq        = dd * dd;
        dist_base = (ax_reg == 2'd0) ? '0 : dist_reg;
        ax_inc    = (ax_reg == vgrt_pkg::LAST_AX) ? 2'd0 : ax_reg + 2'd1;
    end

    // axis with the smallest time, ties go to the later axis
    always_comb
    begin
        if (tm_reg[0] < tm_reg[1])
            sel = (tm_reg[0] < tm_reg[2]) ? 2'd0 : 2'd2;
        else
            sel = (tm_reg[1] < tm_reg[2]) ? 2'd1 : 2'd2;
        tsum = {1'b0, tm_reg[sel]} + {1'b0, inv_reg[sel]};
    end

    always_comb
    begin
        div_bit = (div_cnt_reg == '0);
        for (int a = 0; a < 3; a++)
        begin
            trial[a] = {rem_reg[a], div_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            ax_reg        <= '0;
            steps_reg     <= '0;
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.load)
            begin
                act_reg     <= s_tuser;
                div_cnt_reg <= '0;
                ax_reg      <= '0;
                steps_reg   <= '0;
            end
            if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + vgrt_pkg::DIV_W'(1);
            if (cmd.mul_step || cmd.dist_step)
                ax_reg <= ax_inc;
            if (cmd.adv)
                steps_reg <= steps_reg + SW'(1);
            if (cmd.res_hit || cmd.res_miss)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg    <= s_tdata[4:0];
            vy_reg    <= s_tdata[9:5];
            vz_reg    <= s_tdata[14:10];
            solid_reg <= s_tdata[15];
            lim_reg   <= (2*vgrt_pkg::REACH_W)'(in_reach) * (2*vgrt_pkg::REACH_W)'(in_reach);
            for (int a = 0; a < 3; a++)
            begin
                org_reg[a]  <= in_org[a];
                mag_reg[a]  <= in_dir[a][vgrt_pkg::DIR_W-1] ? 16'(-in_dir[a]) : in_dir[a];
                neg_reg[a]  <= in_dir[a][vgrt_pkg::DIR_W-1];
                zero_reg[a] <= (in_dir[a] == '0) || (in_reach == '0);
                pos_reg[a]  <= PW'(in_rnd[a][16:FRAC_BITS]);
                last_reg[a] <= PW'(in_rnd[a][16:FRAC_BITS]);
                rem_reg[a]  <= '0;
                quo_reg[a]  <= '0;
            end
        end
        if (cmd.div_step)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (trial[a] >= {1'b0, mag_reg[a]})
                begin
                    rem_reg[a] <= 16'(trial[a] - {1'b0, mag_reg[a]});
                    quo_reg[a] <= {quo_reg[a][TW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[a] <= trial[a][vgrt_pkg::DIR_W-1:0];
                    quo_reg[a] <= {quo_reg[a][TW-2:0], 1'b0};
                end
            end
        end
        if (cmd.mul_step)
        begin
            inv_reg[ax_reg] <= inv_src;
            tm_reg[ax_reg]  <= (zero_reg[ax_reg] || t_full[TW]) ? '1 : t_full[TW-1:0];
        end
        if (cmd.dist_step)
            dist_reg <= dist_base + DSW'($unsigned(sq));
        if (cmd.adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                last_reg[a] <= pos_reg[a];
            end
            if (!zero_reg[sel])
            begin
                pos_reg[sel] <= neg_reg[sel] ? pos_reg[sel] - PW'(1) : pos_reg[sel] + PW'(1);
                tm_reg[sel]  <= tsum[TW] ? '1 : tsum[TW-1:0];
            end
        end
        if (cmd.res_hit)
        begin
            hit_reg <= 1'b1;
            hx_reg  <= pos_reg[0][vgrt_pkg::OUT_W-1:0];
            hy_reg  <= pos_reg[1][vgrt_pkg::OUT_W-1:0];
            hz_reg  <= pos_reg[2][vgrt_pkg::OUT_W-1:0];
            px_reg  <= last_reg[0][vgrt_pkg::OUT_W-1:0];
            py_reg  <= last_reg[1][vgrt_pkg::OUT_W-1:0];
            pz_reg  <= last_reg[2][vgrt_pkg::OUT_W-1:0];
        end
        else if (cmd.res_miss)
        begin
            hit_reg <= 1'b0;
            hx_reg  <= '0;
            hy_reg  <= '0;
            hz_reg  <= '0;
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
        end
    end

    assign st.clr_done = (clr_cnt_reg == '1);
    assign st.is_cast  = (act_reg == vgrt_pkg::ACT_CAST);
    assign st.div_done = (div_cnt_reg == vgrt_pkg::DIV_LAST);
    assign st.ax_last  = (ax_reg == vgrt_pkg::LAST_AX);
    assign st.in_grid  = in_grid;
    assign st.solid    = rdata_reg;
    assign st.far      = (dist_reg > DSW'(lim_reg));
    assign st.cap      = (steps_reg == SW'(MAX_STEPS));
    assign st.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {2'b00, pz_reg, py_reg, px_reg, hz_reg, hy_reg, hx_reg};

endmodule

[design/voxel_grid_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// 3D DDA ray walk through a cubic occupancy bitmap with voxel writes.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the occupancy memory is swept to air,
// all 2^(3*GRID_BITS) entries (32768 at the default), with s_tready low. A write
// passes through accept and decode and returns nothing. A cast passes through
// accept, decode, the bit-serial inverse step divider (all axes in parallel),
// the crossing times (one multiplier) and the origin voxel read, then for each
// voxel step the distance squares (three, through one multiplier), compare,
// step, memory read and test, and finally the result; at most MAX_STEPS voxel
// steps. The result state waits while an earlier result is held by m_tready.
// ----------------------------------------------------------------------------
module voxel_grid_ray_traversal
#(
    parameter int GRID_BITS = 5,
    parameter int FRAC_BITS = 10,
    parameter int MAX_STEPS = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // voxel_x, voxel_y, voxel_z, solid, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, reach
    input  logic [vgrt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_x, hit_y, hit_z, prev_x, prev_y, prev_z
    output logic [vgrt_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser    // hit
);

    vgrt_pkg::cmd_t    cmd;
    vgrt_pkg::status_t st;

    vgrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vgrt_dp
    #(
        .GRID_BITS (GRID_BITS),
        .FRAC_BITS (FRAC_BITS),
        .MAX_STEPS (MAX_STEPS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

[design/vgrt_check.sv]
// ----------------------------------------------------------------------------
// vgrt_check
// Port checker for the voxel ray traversal block.
// ----------------------------------------------------------------------------
`include "voxel_grid_ray_traversal_assert.svh"

module vgrt_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [vgrt_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vgrt_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    `VGRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `VGRT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `VGRT_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `VGRT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind voxel_grid_ray_traversal vgrt_check u_check (.*);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal testbench
// Streams voxel writes and ray casts into the block. A built-in predictor
// keeps its own occupancy map and walks each ray with the same fixed-point
// DDA. Every result is checked against the oldest expected one. The run
// goes through phases of sender idling and receiver stalling, and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic             act;
        logic [2:0][4:0]  vox;
        logic             solid;
        logic [2:0][14:0] org;
        logic [2:0][15:0] dir;
        logic [15:0]      reach;
    } ray_item_t;

    typedef struct {
        logic            hit;
        logic [2:0][4:0] hv;
        logic [2:0][4:0] pv;
    } ray_hit_t;

    localparam longint TMAX  = 64'hFFFF_FFFF;
    localparam int     LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [127:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    ray_item_t pend_q[$];
    ray_hit_t  hit_q[$];
    ray_item_t cur;
    bit        occ_map[32768];
    int        n_accepted;
    int        n_items;
    int        n_errors;
    int        src_idle_pct;
    int        dst_stall_pct;
    bit        hold_off;
    int        cycles;

    voxel_grid_ray_traversal u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [127:0] pack_item(ray_item_t it);
        return {3'b0, it.reach, it.dir[2], it.dir[1], it.dir[0],
                it.org[2], it.org[1], it.org[0], it.solid,
                it.vox[2], it.vox[1], it.vox[0]};
    endfunction

    function automatic int vidx(int x, int y, int z);
        return (x << 10) | (y << 5) | z;
    endfunction

    function automatic bit in_grid(int p[3]);
        for (int a = 0; a < 3; a++)
            if (p[a] < 0 || p[a] > 31)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic ray_hit_t walk_ray(ray_item_t it);
        ray_hit_t r;
        longint   org[3];
        int       pos[3];
        int       prv[3];
        int       sg[3];
        longint   inv[3];
        longint   tm[3];
        longint   lim;
        longint   dsq;
        longint   dd;
        longint   bfar;
        int       d;
        int       ax;
        r.hit = 1'b0;
        r.hv  = '0;
        r.pv  = '0;
        lim = longint'(it.reach) * longint'(it.reach);
        for (int a = 0; a < 3; a++)
        begin
            d = int'($signed(it.dir[a]));
            org[a] = longint'(it.org[a]);
            pos[a] = int'((org[a] + 512) >>> 10);
            sg[a] = (it.reach == 0) ? 0 : ((d > 0) ? 1 : ((d < 0) ? -1 : 0));
            if (sg[a] == 0)
            begin
                inv[a] = TMAX;
                tm[a]  = TMAX;
            end
            else
            begin
                inv[a] = (64'd1 << 30) / longint'(d < 0 ? -d : d);
                if (sg[a] > 0)
                    bfar = (longint'(pos[a]) << 10) + 512 - org[a];
                else
                    bfar = org[a] + 512 - (longint'(pos[a]) << 10);
                tm[a] = (inv[a] * bfar) >>> 10;
                if (tm[a] > TMAX)
                    tm[a] = TMAX;
            end
        end
        if (!in_grid(pos))
            return r;
        if (occ_map[vidx(pos[0], pos[1], pos[2])])
        begin
            r.hit = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                r.hv[a] = pos[a][4:0];
                r.pv[a] = pos[a][4:0];
            end
            return r;
        end
        for (int s = 0; s < 256; s++)
        begin
            dsq = 0;
            for (int a = 0; a < 3; a++)
            begin
                dd = org[a] - (longint'(pos[a]) << 10);
                dsq += dd * dd;
            end
            if (dsq > lim)
                return r;
            if (tm[0] < tm[1])
                ax = (tm[0] < tm[2]) ? 0 : 2;
            else
                ax = (tm[1] < tm[2]) ? 1 : 2;
            prv = pos;
            if (sg[ax] != 0)
            begin
                pos[ax] += sg[ax];
                tm[ax] = tm[ax] + inv[ax];
                if (tm[ax] > TMAX)
                    tm[ax] = TMAX;
            end
            if (!in_grid(pos))
                return r;
            if (occ_map[vidx(pos[0], pos[1], pos[2])])
            begin
                r.hit = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    r.hv[a] = pos[a][4:0];
                    r.pv[a] = prv[a][4:0];
                end
                return r;
            end
        end
        return r;
    endfunction

    function automatic void apply_item(ray_item_t it);
        if (it.act == vgrt_pkg::ACT_WRITE)
            occ_map[vidx(it.vox[0], it.vox[1], it.vox[2])] = it.solid;
        else
            hit_q.push_back(walk_ray(it));
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic ray_item_t mk_write(int x, int y, int z, bit sol);
        ray_item_t it;
        it = '{default: '0};
        it.act = vgrt_pkg::ACT_WRITE;
        it.vox[0] = 5'(x);
        it.vox[1] = 5'(y);
        it.vox[2] = 5'(z);
        it.solid = sol;
        return it;
    endfunction

    function automatic ray_item_t mk_cast(int ox, int oy, int oz, int dx, int dy, int dz,
                                          int rch);
        ray_item_t it;
        it = '{default: '0};
        it.act = vgrt_pkg::ACT_CAST;
        it.org[0] = 15'(ox);
        it.org[1] = 15'(oy);
        it.org[2] = 15'(oz);
        it.dir[0] = 16'(dx);
        it.dir[1] = 16'(dy);
        it.dir[2] = 16'(dz);
        it.reach = 16'(rch);
        return it;
    endfunction

    function automatic ray_item_t rand_item();
        ray_item_t it;
        int        r;
        it.act   = ($urandom_range(0, 99) < 60) ? vgrt_pkg::ACT_CAST : vgrt_pkg::ACT_WRITE;
        it.solid = ($urandom_range(0, 99) < 70);
        for (int a = 0; a < 3; a++)
        begin
            it.vox[a] = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(6, 14))
                                                    : 5'($urandom_range(0, 31));
            it.org[a] = ($urandom_range(0, 99) < 80) ? 15'($urandom_range(2048, 20480))
                                                    : 15'($urandom_range(0, 32767));
            r = $urandom_range(0, 99);
            if (r < 5)
                it.dir[a] = '0;
            else if (r < 15)
                it.dir[a] = 16'($urandom());
            else
                it.dir[a] = 16'($urandom_range(0, 32768) - 16384);
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            it.reach = '0;
        else if (r < 13)
            it.reach = 16'($urandom());
        else
            it.reach = 16'($urandom_range(1, 30720));
        return it;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            n_accepted <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_item(cur);
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    cur = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_item(cur);
                    s_tuser  <= cur.act;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (hit_q.size() == 0)
                begin
                    report("unexpected result", m_tdata, '0);
                end
                else
                begin
                    ray_hit_t e;
                    e = hit_q.pop_front();
                    if (m_tuser !== e.hit)
                        report("hit", m_tuser, e.hit);
                    if (m_tdata[14:0] !== e.hv)
                        report("hit voxel", m_tdata[14:0], e.hv);
                    if (m_tdata[29:15] !== e.pv)
                        report("prev voxel", m_tdata[29:15], e.pv);
                end
            end
            m_tready <= !hold_off && ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("** voxel_grid_ray_traversal: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (n_accepted < 150)
        begin
            src_idle_pct  <= 0;
            dst_stall_pct <= 0;
        end
        else if (n_accepted < 275)
        begin
            src_idle_pct  <= 77;
            dst_stall_pct <= 0;
        end
        else if (n_accepted < 400)
        begin
            src_idle_pct  <= 0;
            dst_stall_pct <= 77;
        end
        else
        begin
            src_idle_pct  <= 37;
            dst_stall_pct <= 37;
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (n_accepted >= 40);
        hold_off = 1'b1;
        repeat (5000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        n_errors = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        // directed: corners, origin solid, rounding, extremes of dir and reach
        pend_q.push_back(mk_write(0, 0, 0, 1));
        pend_q.push_back(mk_write(31, 31, 31, 1));
        pend_q.push_back(mk_cast(0, 0, 0, 16384, 0, 0, 4096));
        pend_q.push_back(mk_cast(1000, 1000, 1000, -16384, -16384, -16384, 65535));
        pend_q.push_back(mk_cast(30720, 30720, 30720, 16384, 16384, 16384, 65535));
        pend_q.push_back(mk_cast(31743, 31743, 31743, 16384, 16384, 16384, 65535));
        pend_q.push_back(mk_cast(32767, 32767, 32767, 16384, 0, 0, 1024));
        pend_q.push_back(mk_cast(511, 512, 0, 0, 0, 0, 65535));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 0, 0, 0, 0));
        pend_q.push_back(mk_write(20, 5, 5, 1));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 16384, 0, 0, 65535));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 32767, 1, 0, 65535));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 16384, 0, 0, 5000));
        pend_q.push_back(mk_cast(25600, 5120, 5120, -32768, 0, 0, 65535));
        pend_q.push_back(mk_cast(5120, 5120, 5120, -16384, 0, 0, 65535));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 16384, 16384, 16384, 65535));
        pend_q.push_back(mk_write(20, 5, 5, 0));
        pend_q.push_back(mk_write(0, 0, 0, 0));
        pend_q.push_back(mk_write(31, 31, 31, 0));
        pend_q.push_back(mk_cast(5120, 5120, 5120, 16384, 0, 0, 65535));
        for (int i = 0; i < 500; i++)
            pend_q.push_back(rand_item());
        n_items = pend_q.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (n_accepted == n_items && hit_q.size() == 0);
        repeat (2000) @(posedge clk);
        if (n_errors == 0 && hit_q.size() == 0)
            $display("** voxel_grid_ray_traversal: PASSED **");
        else
            $display("** voxel_grid_ray_traversal: FAILED **");
        $finish;
    end
endmodule
